FILE: src/wdp_pkg.sv
// ============================================================================
// wdp_pkg - shared types and constants of the WebP dimension parser
// Item and result types, parse phases, chunk tags and status codes.
// ============================================================================
package wdp_pkg;

    // Little-endian tags, as they build up in the 32-bit shift register
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
    localparam logic [31:0] TAG_VP8X = 32'h5838_5056;
    localparam logic [31:0] TAG_VP8  = 32'h2038_5056;
    localparam logic [31:0] TAG_VP8L = 32'h4C38_5056;

    localparam int unsigned DIM_BITS   = 14;
    localparam logic [3:0]  HDR_LAST   = 4'd11;  // last byte of the 12-byte header
    localparam logic [3:0]  TAG_LAST   = 4'd3;
    localparam logic [3:0]  SIZE_LAST  = 4'd7;

    // Result status codes
    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_NO_IMAGE   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    // Image formats
    localparam logic [1:0] FMT_VP8X = 2'd0;
    localparam logic [1:0] FMT_VP8  = 2'd1;
    localparam logic [1:0] FMT_VP8L = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CHUNK   = 3'd1,
        PH_SKIP    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_IDLE    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [24:0] image_width;
        logic [24:0] image_height;
        logic [1:0]  image_format;
    } result_t;

endpackage

FILE: src/wdp_if.sv
// ============================================================================
// wdp_byte_if / wdp_result_if - valid/ready channels of the parser
// One interface for the byte stream, one for the result items.
// ============================================================================
interface wdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output final_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input final_byte, output ready);
endinterface

interface wdp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [24:0] image_width;
    logic [24:0] image_height;
    logic [1:0]  image_format;

    modport source (output valid, output status, output image_width,
                    output image_height, output image_format, input ready);
    modport sink   (input valid, input status, input image_width,
                    input image_height, input image_format, output ready);
endinterface

FILE: src/wdp_in_stage.sv
// ============================================================================
// wdp_in_stage - input register
// Captures one byte transfer; frees up when the parse step consumes it.
// ============================================================================
module wdp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    wdp_byte_if.sink           bytes,
    input  logic               advance,
    output logic               item_valid,
    output wdp_pkg::in_item_t  item
);

    logic              valid_reg;
    wdp_pkg::in_item_t item_reg;

    assign bytes.ready = !valid_reg || advance;
    assign item_valid  = valid_reg;
    assign item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            item_reg.data_byte  <= bytes.data_byte;
            item_reg.first_byte <= bytes.first_byte;
            item_reg.final_byte <= bytes.final_byte;
        end
    end

endmodule

FILE: src/wdp_parse.sv
// ============================================================================
// wdp_parse - RIFF/WebP chunk walker
// Holds the parse state and advances it by one byte per step.
// ============================================================================
module wdp_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  wdp_pkg::in_item_t  item,
    output logic               res_valid,
    output wdp_pkg::result_t   res
);

    wdp_pkg::phase_t phase_reg,       phase_next;
    logic [3:0]      byte_index_reg,  byte_index_next;
    logic [31:0]     tag_shift_reg,   tag_shift_next;
    logic [31:0]     chunk_tag_reg,   chunk_tag_next;
    logic [32:0]     skip_left_reg,   skip_left_next;
    logic [47:0]     dim_bytes_reg,   dim_bytes_next;
    logic [1:0]      format_kind_reg, format_kind_next;

    // state as seen by this byte (a start mark restarts from reset values)
    wdp_pkg::phase_t ph;
    logic [3:0]      bi;
    logic [31:0]     ts_new;
    logic [32:0]     skip_dec;
    logic [3:0]      lo, hi, lane;
    logic [31:0]     word;
    logic [7:0]      b;

    assign b = item.data_byte;

    always_comb
    begin
        ph               = item.first_byte ? wdp_pkg::PH_HEADER : phase_reg;
        bi               = item.first_byte ? 4'd0 : byte_index_reg;
        tag_shift_next   = item.first_byte ? 32'd0 : tag_shift_reg;
        chunk_tag_next   = item.first_byte ? 32'd0 : chunk_tag_reg;
        skip_left_next   = item.first_byte ? 33'd0 : skip_left_reg;
        dim_bytes_next   = item.first_byte ? 48'd0 : dim_bytes_reg;
        format_kind_next = item.first_byte ? 2'd0 : format_kind_reg;
        phase_next       = ph;
        byte_index_next  = bi;

        ts_new   = {b, tag_shift_next[31:8]};
        skip_dec = skip_left_next - 33'd1;
        word     = 32'd0;
        lo       = 4'd1;
        hi       = 4'd4;
        lane     = 4'd0;

        res_valid        = 1'b0;
        res.status       = wdp_pkg::ST_FOUND;
        res.image_width  = 25'd0;
        res.image_height = 25'd0;
        res.image_format = wdp_pkg::FMT_VP8X;

        case (ph)
            wdp_pkg::PH_HEADER:
            begin
                tag_shift_next = ts_new;
                if ((bi == wdp_pkg::TAG_LAST && ts_new != wdp_pkg::TAG_RIFF) ||
                    (bi == wdp_pkg::HDR_LAST && ts_new != wdp_pkg::TAG_WEBP))
                begin
                    res_valid  = 1'b1;
                    res.status = wdp_pkg::ST_BAD_HEADER;
                    phase_next = wdp_pkg::PH_IDLE;
                end
                else if (bi == wdp_pkg::HDR_LAST)
                begin
                    phase_next      = wdp_pkg::PH_CHUNK;
                    byte_index_next = 4'd0;
                end
                else
                begin
                    byte_index_next = bi + 4'd1;
                end
            end
            wdp_pkg::PH_CHUNK:
            begin
                tag_shift_next = ts_new;
                if (bi == wdp_pkg::TAG_LAST)
                begin
                    chunk_tag_next = ts_new;
                end
                if (bi == wdp_pkg::SIZE_LAST)
                begin
                    byte_index_next = 4'd0;
                    dim_bytes_next  = 48'd0;
                    if (chunk_tag_next == wdp_pkg::TAG_VP8X)
                    begin
                        format_kind_next = wdp_pkg::FMT_VP8X;
                        phase_next       = wdp_pkg::PH_PAYLOAD;
                    end
                    else if (chunk_tag_next == wdp_pkg::TAG_VP8)
                    begin
                        format_kind_next = wdp_pkg::FMT_VP8;
                        phase_next       = wdp_pkg::PH_PAYLOAD;
                    end
                    else if (chunk_tag_next == wdp_pkg::TAG_VP8L)
                    begin
                        format_kind_next = wdp_pkg::FMT_VP8L;
                        phase_next       = wdp_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        // payload padded to even length
                        skip_left_next = {1'b0, ts_new} + {32'd0, ts_new[0]};
                        phase_next     = (ts_new == 32'd0) ? wdp_pkg::PH_CHUNK
                                                           : wdp_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    byte_index_next = bi + 4'd1;
                end
            end
            wdp_pkg::PH_SKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == 33'd0)
                begin
                    phase_next      = wdp_pkg::PH_CHUNK;
                    byte_index_next = 4'd0;
                end
            end
            wdp_pkg::PH_PAYLOAD:
            begin
                case (format_kind_next)
                    wdp_pkg::FMT_VP8X:
                    begin
                        lo = 4'd4;
                        hi = 4'd9;
                    end
                    wdp_pkg::FMT_VP8:
                    begin
                        lo = 4'd6;
                        hi = 4'd9;
                    end
                    default:
                    begin
                        lo = 4'd1;
                        hi = 4'd4;
                    end
                endcase
                lane = bi - lo;
                if (bi >= lo && bi <= hi)
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        if (lane == 4'(k))
                        begin
                            dim_bytes_next[8*k +: 8] = b;
                        end
                    end
                end
                word = dim_bytes_next[31:0];
                if (bi >= hi)
                begin
                    res_valid        = 1'b1;
                    res.status       = wdp_pkg::ST_FOUND;
                    res.image_format = format_kind_next;
                    case (format_kind_next)
                        wdp_pkg::FMT_VP8X:
                        begin
                            res.image_width  = {1'b0, dim_bytes_next[23:0]} + 25'd1;
                            res.image_height = {1'b0, dim_bytes_next[47:24]} + 25'd1;
                        end
                        wdp_pkg::FMT_VP8:
                        begin
                            res.image_width  = 25'(word[13:0]);
                            res.image_height = 25'(word[29:16]);
                        end
                        default:
                        begin
                            res.image_width  = 25'(word[13:0]) + 25'd1;
                            res.image_height = 25'(word[2*wdp_pkg::DIM_BITS-1:
                                                        wdp_pkg::DIM_BITS]) + 25'd1;
                        end
                    endcase
                    phase_next = wdp_pkg::PH_IDLE;
                end
                else
                begin
                    byte_index_next = bi + 4'd1;
                end
            end
            default:
            begin
            end
        endcase

        // end of file before a result: error by where the walk stopped
        if (item.final_byte && !res_valid && phase_next != wdp_pkg::PH_IDLE)
        begin
            res_valid = 1'b1;
            if (phase_next == wdp_pkg::PH_HEADER)
            begin
                res.status = wdp_pkg::ST_BAD_HEADER;
            end
            else if (phase_next == wdp_pkg::PH_PAYLOAD)
            begin
                res.status = wdp_pkg::ST_TRUNCATED;
            end
            else
            begin
                res.status = wdp_pkg::ST_NO_IMAGE;
            end
        end
        if (item.final_byte)
        begin
            phase_next = wdp_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= wdp_pkg::PH_HEADER;
            byte_index_reg  <= 4'd0;
            tag_shift_reg   <= 32'd0;
            chunk_tag_reg   <= 32'd0;
            skip_left_reg   <= 33'd0;
            dim_bytes_reg   <= 48'd0;
            format_kind_reg <= 2'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            tag_shift_reg   <= tag_shift_next;
            chunk_tag_reg   <= chunk_tag_next;
            skip_left_reg   <= skip_left_next;
            dim_bytes_reg   <= dim_bytes_next;
            format_kind_reg <= format_kind_next;
        end
    end

endmodule

FILE: src/wdp_out_stage.sv
// ============================================================================
// wdp_out_stage - result register
// Holds one result until its transfer completes.
// ============================================================================
module wdp_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  wdp_pkg::result_t   res,
    output logic               free,
    wdp_result_if.source       result
);

    logic             valid_reg;
    wdp_pkg::result_t res_reg;

    assign free                = !valid_reg || result.ready;
    assign result.valid        = valid_reg;
    assign result.status       = res_reg.status;
    assign result.image_width  = res_reg.image_width;
    assign result.image_height = res_reg.image_height;
    assign result.image_format = res_reg.image_format;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: src/webp_dimension_parser.sv
// ============================================================================
// webp_dimension_parser - WebP canvas size and format extractor
// Checks the RIFF/WEBP header, walks the chunk list and reports the canvas
// size of the first VP8X, VP8 or VP8L chunk, or why none was found.
// ============================================================================
//
//  Channel  Dir  Payload                                          Handshake
//  -------  ---  -----------------------------------------------  ----------
//  bytes    in   data_byte[7:0], first_byte, final_byte           valid/ready
//  result   out  status[1:0], image_width[24:0],                  valid/ready
//                image_height[24:0], image_format[1:0]
//
//  One byte per clock sustained while no result is held back. Input register
//  -> parse step -> result register: result.valid rises when the result
//  register takes the outcome of the byte held in the input register.
//  The parse step is a short compare / 33-bit decrement / 25-bit add path.
//  Reset (rst_n low, async) puts the parser at byte 0 and empties both regs.
//  A held result with result.ready low stops the parse step; bytes.ready
//  falls once the input register is full.
//
module webp_dimension_parser
(
    input  logic          clk,
    input  logic          rst_n,
    wdp_byte_if.sink      bytes,
    wdp_result_if.source  result
);

    logic              item_valid;
    wdp_pkg::in_item_t item;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    wdp_pkg::result_t  res;

    // a held byte is consumed only when the result register can take the
    // outcome, so no result is ever dropped
    assign advance = item_valid && out_free;

    wdp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wdp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    wdp_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && res_valid),
        .res    (res),
        .free   (out_free),
        .result (result)
    );

endmodule
